@@ hw/rtl/uf_pkg.sv @@
// Package for the disjoint-set engine: table size, node index type,
// item structs, controller state encoding and controller/datapath links.
// No dependencies.
`default_nettype none

package uf_pkg;

  // Parent table size and index width
  localparam int NODE_COUNT = 256;
  localparam int NODE_W     = 8;

  typedef logic [NODE_W-1:0] node_t;

  // Operation codes
  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNION = 1'b1;

  // Input beat
  typedef struct packed {
    logic  op;
    node_t node_a;
    node_t node_b;
  } uf_in_t;

  // Result beat
  typedef struct packed {
    logic  same_set;
    node_t root_a;
    node_t root_b;
  } uf_out_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,     // walk parent links toward the root
    S_FIX,    // rewrite the walked path to point at the root
    S_NEXT,   // hand over from node_a to node_b
    S_RES,    // capture root of node_b
    S_MRG_A,  // union: rewrite root_a
    S_MRG_B,  // union: rewrite root_b
    S_DONE    // present result
  } uf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic up_step;
    logic fix_begin;
    logic fix_step;
    logic next_b;
    logic save_b;
    logic mrg_a;
    logic mrg_b;
    logic emit;
  } uf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic up_is_cur;
    logic node_is_cur;
    logic up_is_root;
    logic op;
  } uf_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/uf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/uf_datapath.sv @@
// Datapath of the disjoint-set engine: parent table RAM with per-entry
// valid bits, walk registers and result registers. Uses uf_pkg and uf_ram.
`default_nettype none

module uf_datapath
  import uf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire uf_cmd_t cmd,
  input  wire uf_in_t  in_item,
  output uf_stat_t     stat,
  output uf_out_t      out_item
);

  // Request and walk registers
  logic  op_r,     op_nxt;
  node_t b_r,      b_nxt;
  node_t cur_r,    cur_nxt;
  node_t node_r,   node_nxt;
  node_t walk_r,   walk_nxt;
  node_t root_r,   root_nxt;
  node_t root_a_r, root_a_nxt;
  node_t root_b_r, root_b_nxt;

  // Table access
  logic [NODE_COUNT-1:0] valid_r;
  logic  vld_q_r;
  node_t raddr_q_r;
  node_t ram_q;
  node_t rdata;
  logic  rd_en;
  node_t rd_addr;
  logic  wr_en;
  node_t wr_addr;
  node_t wr_data;
  node_t low_root;

  // An entry never written still holds its own index
  assign rdata    = vld_q_r ? ram_q : raddr_q_r;
  assign low_root = (root_a_r < root_b_r) ? root_a_r : root_b_r;

  // Read address select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = rdata;
    if (cmd.load) begin
      rd_addr = in_item.node_a;
    end else if (cmd.fix_begin) begin
      rd_addr = node_r;
    end else if (cmd.next_b) begin
      rd_addr = b_r;
    end else if (!(cmd.up_step || cmd.fix_step)) begin
      rd_en = 1'b0;
    end
  end

  // Write address and data select
  always_comb begin
    wr_en   = cmd.fix_step || cmd.mrg_a || cmd.mrg_b;
    wr_addr = walk_r;
    wr_data = root_r;
    if (cmd.mrg_a) begin
      wr_addr = root_a_r;
      wr_data = low_root;
    end else if (cmd.mrg_b) begin
      wr_addr = root_b_r;
      wr_data = low_root;
    end
  end

  uf_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Valid bits: set on first write, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Read side tags, aligned with the RAM output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q_r   <= valid_r[rd_addr];
      raddr_q_r <= rd_addr;
    end
  end

  // Walk register updates
  always_comb begin
    op_nxt     = op_r;
    b_nxt      = b_r;
    cur_nxt    = cur_r;
    node_nxt   = node_r;
    walk_nxt   = walk_r;
    root_nxt   = root_r;
    root_a_nxt = root_a_r;
    root_b_nxt = root_b_r;
    if (cmd.load) begin
      op_nxt   = in_item.op;
      b_nxt    = in_item.node_b;
      cur_nxt  = in_item.node_a;
      node_nxt = in_item.node_a;
    end
    if (cmd.up_step) begin
      cur_nxt = rdata;
    end
    if (cmd.fix_begin) begin
      root_nxt = cur_r;
      walk_nxt = node_r;
    end
    if (cmd.fix_step) begin
      walk_nxt = rdata;
    end
    if (cmd.next_b) begin
      root_a_nxt = root_r;
      cur_nxt    = b_r;
      node_nxt   = b_r;
    end
    if (cmd.save_b) begin
      root_b_nxt = root_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    node_r   <= node_nxt;
    walk_r   <= walk_nxt;
    root_r   <= root_nxt;
    root_a_r <= root_a_nxt;
    root_b_r <= root_b_nxt;
  end

  // Status back to the controller
  assign stat.up_is_cur   = (rdata == cur_r);
  assign stat.node_is_cur = (node_r == cur_r);
  assign stat.up_is_root  = (rdata == root_r);
  assign stat.op          = op_r;

  // Result beat
  assign out_item.same_set = (root_a_r == root_b_r);
  assign out_item.root_a   = root_a_r;
  assign out_item.root_b   = root_b_r;

`ifndef NO_ASSERTIONS
  // Path rewrite never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("table read and write hit the same entry");

  // Parents always point to a smaller index, so the walk descends
  a_walk_descends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.up_step |-> (rdata < cur_r))
    else $error("parent link does not descend");

  // Second union write follows the first
  a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mrg_b |-> $past(cmd.mrg_a))
    else $error("union write out of order");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/uf_ctrl.sv @@
// Controller of the disjoint-set engine: sequences the root walk, path
// rewrite and union writes for both nodes. Uses uf_pkg.
`default_nettype none

module uf_ctrl
  import uf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire uf_stat_t stat,
  output logic          busy,
  output uf_cmd_t       cmd
);

  uf_state_t state_r, state_nxt;
  logic      phase_r, phase_nxt;   // 0: node_a, 1: node_b

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_UP;
          phase_nxt = 1'b0;
        end
      end
      S_UP: begin
        if (stat.up_is_cur) begin
          if (!stat.node_is_cur) begin
            state_nxt = S_FIX;
          end else begin
            state_nxt = phase_r ? S_RES : S_NEXT;
          end
        end
      end
      S_FIX: begin
        if (stat.up_is_root) begin
          state_nxt = phase_r ? S_RES : S_NEXT;
        end
      end
      S_NEXT: begin
        state_nxt = S_UP;
        phase_nxt = 1'b1;
      end
      S_RES: begin
        state_nxt = (stat.op == OP_UNION) ? S_MRG_A : S_DONE;
      end
      S_MRG_A: state_nxt = S_MRG_B;
      S_MRG_B: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_UP: begin
        cmd.fix_begin = stat.up_is_cur;
        cmd.up_step   = !stat.up_is_cur;
      end
      S_FIX:   cmd.fix_step = 1'b1;
      S_NEXT:  cmd.next_b   = 1'b1;
      S_RES:   cmd.save_b   = 1'b1;
      S_MRG_A: cmd.mrg_a    = 1'b1;
      S_MRG_B: cmd.mrg_b    = 1'b1;
      S_DONE:  cmd.emit     = 1'b1;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // An accepted beat starts the root walk
  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_UP && !phase_r))
    else $error("accepted beat did not start the walk");

  // Result strobe lasts one cycle and frees the engine
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (!cmd.emit && !busy))
    else $error("result strobe not followed by idle");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/union_find_engine.sv @@
// Top level of the disjoint-set (union-find) engine with path compression.
// Instantiates uf_ctrl and uf_datapath; uses uf_pkg.
`default_nettype none

// A beat is taken when start is high and busy is low. Each beat gives one
// result, shown for a single cycle with out_valid high; the receiver cannot
// stall it. For each node the engine walks parent links one table read per
// cycle, then rewrites the walked path one entry per cycle, all through the
// single parent table RAM. The engine takes no new beat until the result has
// been shown, and a union adds the two root writes after both walks.
// After reset every node is its own root; no clearing pass is needed.
module union_find_engine
  import uf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  output logic        busy,
  input  wire uf_in_t in_item,
  output logic        out_valid,
  output uf_out_t     out_item
);

  uf_cmd_t  cmd;
  uf_stat_t stat;

  uf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  uf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

  assign out_valid = cmd.emit;

endmodule

`default_nettype wire
